FILE: hw/rtl/aivdm_pkg.sv
// Shared types, character codes and helper functions for the AIVDM sentence parser.
// Used by aivdm_in_skid, aivdm_core and nmea_aivdm_sentence_parser_unit.
`timescale 1ns / 1ps

package aivdm_pkg;

    // Line and payload limits.
    localparam logic [7:0] MAX_LINE_LEN = 8'd128;
    localparam logic [6:0] MAX_PAYLOAD  = 7'd80;

    // Bus widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;

    // Character codes.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DOLR  = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;

    // Armoring offsets.
    localparam logic [7:0] ARMOR_BASE  = 8'd48;
    localparam logic [7:0] ARMOR_SPLIT = 8'd88;
    localparam logic [7:0] ARMOR_GAP   = 8'd8;

    // Result kinds.
    localparam logic KIND_SYMBOL  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_START = 3'd1;
    localparam logic [2:0] ST_CHECKSUM = 3'd2;
    localparam logic [2:0] ST_NOT_VDM  = 3'd3;
    localparam logic [2:0] ST_FIELD    = 3'd4;
    localparam logic [2:0] ST_TOO_LONG = 3'd5;

    // One result item.
    typedef struct packed {
        logic       item_kind;
        logic [5:0] symbol;
        logic [2:0] status;
        logic [7:0] frag_total;
        logic [7:0] frag_number;
        logic [7:0] sequence_id;
        logic       sequence_present;
        logic [7:0] channel_code;
        logic [6:0] payload_count;
    } t_result;

    // Uppercase hex character for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'd0, nib};
        if (nib < 4'd10) begin
            hex_char = CH_ZERO + ext;
        end else begin
            hex_char = CH_UPA + ext - 8'd10;
        end
    endfunction

    // Expected character of the sentence type at a given position.
    function automatic logic [7:0] type_char(input logic [2:0] pos);
        unique case (pos)
            3'd0:    type_char = 8'h41; // A
            3'd1:    type_char = 8'h49; // I
            3'd2:    type_char = 8'h56; // V
            3'd3:    type_char = 8'h44; // D
            3'd4:    type_char = 8'h4D; // M
            default: type_char = 8'h00;
        endcase
    endfunction

endpackage

FILE: hw/rtl/aivdm_in_skid.sv
// Two-entry input skid buffer for the received byte stream.
// Depends on aivdm_pkg for the byte width.
`timescale 1ns / 1ps

module aivdm_in_skid
    import aivdm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_data,
    output logic                  o_head_valid,
    output logic [IN_TDATA_W-1:0] o_head_data,
    input  logic                  i_pop
);

    logic                  r_a_valid;
    logic [IN_TDATA_W-1:0] r_a_data;
    logic                  r_b_valid;
    logic [IN_TDATA_W-1:0] r_b_data;
    logic                  accept;

    // Ready depends on registered state only.
    assign o_ready      = !r_b_valid;
    assign accept       = i_valid && !r_b_valid;
    assign o_head_valid = r_a_valid;
    assign o_head_data  = r_a_data;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_pop) begin
            if (r_b_valid) begin
                r_a_valid <= 1'b1;
                r_b_valid <= 1'b0;
            end else begin
                r_a_valid <= accept;
            end
        end else if (!r_a_valid) begin
            r_a_valid <= accept;
        end else if (accept) begin
            r_b_valid <= 1'b1;
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (r_b_valid) begin
                r_a_data <= r_b_data;
            end else begin
                r_a_data <= i_data;
            end
        end else if (!r_a_valid) begin
            r_a_data <= i_data;
        end else if (accept) begin
            r_b_data <= i_data;
        end
    end

endmodule

FILE: hw/rtl/aivdm_core.sv
// Per-byte sentence parser: line state registers and their single-pass update.
// Depends on aivdm_pkg for codes, limits and the result type.
`timescale 1ns / 1ps

module aivdm_core
    import aivdm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic [7:0] i_byte,
    input  logic       i_out_free,
    output logic       o_take,
    output logic       o_emit,
    output t_result    o_result
);

    // Line phases.
    localparam logic [2:0] PH_SEARCH = 3'd0;
    localparam logic [2:0] PH_BODY   = 3'd1;
    localparam logic [2:0] PH_HEX1   = 3'd2;
    localparam logic [2:0] PH_HEX2   = 3'd3;
    localparam logic [2:0] PH_TAIL   = 3'd4;
    localparam logic [2:0] PH_LFWAIT = 3'd5;
    localparam logic [2:0] PH_BAD    = 3'd6;

    logic [2:0] r_phase,       n_phase;
    logic [7:0] r_xor_acc,     n_xor_acc;
    logic [7:0] r_hex_hold,    n_hex_hold;
    logic [2:0] r_field_num,   n_field_num;
    logic [2:0] r_type_pos,    n_type_pos;
    logic [7:0] r_num_acc,     n_num_acc;
    logic [7:0] r_frag_total,  n_frag_total;
    logic [7:0] r_frag_number, n_frag_number;
    logic [7:0] r_seq_id,      n_seq_id;
    logic       r_seq_present, n_seq_present;
    logic [7:0] r_channel,     n_channel;
    logic [6:0] r_payload_len, n_payload_len;
    logic [7:0] r_line_len,    n_line_len;
    logic [2:0] r_error_code,  n_error_code;

    logic        emit;
    logic [2:0]  verdict_status;
    logic [5:0]  sym;
    logic [7:0]  sym_full;
    logic [11:0] dec_sum;
    logic [7:0]  digit;
    logic        is_digit;

    // Decimal accumulate with saturation, and payload de-armoring.
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = i_byte - CH_ZERO;
    assign dec_sum  = {1'b0, r_num_acc, 3'd0} + {3'd0, r_num_acc, 1'b0} + {4'd0, digit};
    assign sym_full = i_byte - ARMOR_BASE - ((i_byte > ARMOR_SPLIT) ? ARMOR_GAP : 8'd0);
    assign sym      = sym_full[5:0];

    // Verdict status by priority.
    always_comb begin
        if (r_phase == PH_SEARCH) begin
            verdict_status = ST_NO_START;
        end else if (r_error_code == ST_TOO_LONG) begin
            verdict_status = ST_TOO_LONG;
        end else if (r_phase == PH_TAIL || r_phase == PH_LFWAIT) begin
            verdict_status = r_error_code;
        end else begin
            verdict_status = ST_CHECKSUM;
        end
    end

    // Next state and result for the byte at the head of the input.
    always_comb begin
        n_phase       = r_phase;
        n_xor_acc     = r_xor_acc;
        n_hex_hold    = r_hex_hold;
        n_field_num   = r_field_num;
        n_type_pos    = r_type_pos;
        n_num_acc     = r_num_acc;
        n_frag_total  = r_frag_total;
        n_frag_number = r_frag_number;
        n_seq_id      = r_seq_id;
        n_seq_present = r_seq_present;
        n_channel     = r_channel;
        n_payload_len = r_payload_len;
        n_line_len    = r_line_len;
        n_error_code  = r_error_code;
        emit          = 1'b0;

        o_result.item_kind        = KIND_SYMBOL;
        o_result.symbol           = sym;
        o_result.status           = ST_OK;
        o_result.frag_total       = r_frag_total;
        o_result.frag_number      = r_frag_number;
        o_result.sequence_id      = r_seq_id;
        o_result.sequence_present = r_seq_present;
        o_result.channel_code     = r_channel;
        o_result.payload_count    = r_payload_len + 7'd1;

        if (i_byte == CH_LF) begin
            // End of line: verdict, then clear everything.
            emit                   = 1'b1;
            o_result.item_kind     = KIND_VERDICT;
            o_result.symbol        = 6'd0;
            o_result.status        = verdict_status;
            o_result.payload_count = r_payload_len;
            n_phase       = PH_SEARCH;
            n_xor_acc     = 8'd0;
            n_hex_hold    = 8'd0;
            n_field_num   = 3'd0;
            n_type_pos    = 3'd0;
            n_num_acc     = 8'd0;
            n_frag_total  = 8'd0;
            n_frag_number = 8'd0;
            n_seq_id      = 8'd0;
            n_seq_present = 1'b0;
            n_channel     = 8'd0;
            n_payload_len = 7'd0;
            n_line_len    = 8'd0;
            n_error_code  = ST_OK;
        end else begin
            if (r_line_len != 8'hFF) begin
                n_line_len = r_line_len + 8'd1;
            end

            unique case (r_phase)
                PH_SEARCH: begin
                    if (i_byte == CH_BANG || i_byte == CH_DOLR) begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (i_byte != CH_STAR) begin
                        n_xor_acc = r_xor_acc ^ i_byte;
                    end
                    if (i_byte == CH_STAR || i_byte == CH_COMMA) begin
                        // Close the current field.
                        unique case (r_field_num)
                            3'd0: begin
                                if (r_type_pos != 3'd5 && n_error_code == ST_OK) begin
                                    n_error_code = ST_NOT_VDM;
                                end
                            end
                            3'd1:    n_frag_total  = r_num_acc;
                            3'd2:    n_frag_number = r_num_acc;
                            3'd3:    n_seq_id      = r_num_acc;
                            default: ;
                        endcase
                        if (i_byte == CH_STAR) begin
                            if (r_field_num < 3'd5 && n_error_code == ST_OK) begin
                                n_error_code = ST_FIELD;
                            end
                            n_hex_hold = r_xor_acc;
                            n_phase    = PH_HEX1;
                        end else begin
                            if (r_field_num < 3'd6) begin
                                n_field_num = r_field_num + 3'd1;
                            end
                            n_num_acc = 8'd0;
                        end
                    end else if (r_field_num == 3'd0) begin
                        // Sentence type must read AIVDM.
                        if (r_type_pos < 3'd5 && i_byte == type_char(r_type_pos)) begin
                            n_type_pos = r_type_pos + 3'd1;
                        end else if (r_error_code == ST_OK) begin
                            n_error_code = ST_NOT_VDM;
                        end
                    end else if (r_field_num <= 3'd3) begin
                        // Numeric header fields.
                        if (r_field_num == 3'd3) begin
                            n_seq_present = 1'b1;
                        end
                        if (is_digit) begin
                            n_num_acc = (dec_sum > 12'd255) ? 8'hFF : dec_sum[7:0];
                        end else if (r_error_code == ST_OK) begin
                            n_error_code = ST_FIELD;
                        end
                    end else if (r_field_num == 3'd4) begin
                        // Channel: keep the first character only.
                        if (r_num_acc == 8'd0) begin
                            n_channel = i_byte;
                            n_num_acc = 8'd1;
                        end
                    end else if (r_field_num == 3'd5 && r_error_code == ST_OK) begin
                        // Payload symbol.
                        if (r_payload_len >= MAX_PAYLOAD) begin
                            n_error_code = ST_TOO_LONG;
                        end else begin
                            n_payload_len = r_payload_len + 7'd1;
                            emit          = 1'b1;
                        end
                    end
                end
                PH_HEX1: begin
                    n_phase = (i_byte == hex_char(r_hex_hold[7:4])) ? PH_HEX2 : PH_BAD;
                end
                PH_HEX2: begin
                    n_phase = (i_byte == hex_char(r_hex_hold[3:0])) ? PH_TAIL : PH_BAD;
                end
                PH_TAIL: begin
                    n_phase = (i_byte == CH_CR) ? PH_LFWAIT : PH_BAD;
                end
                default: begin
                    n_phase = PH_BAD;
                end
            endcase

            // Overlong started line.
            if (n_phase != PH_SEARCH && n_line_len > MAX_LINE_LEN) begin
                n_error_code = ST_TOO_LONG;
            end
        end
    end

    // A byte moves on unless its result has nowhere to go.
    assign o_take = i_byte_valid && (!emit || i_out_free);
    assign o_emit = i_byte_valid && emit && i_out_free;

    // Line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SEARCH;
            r_xor_acc     <= 8'd0;
            r_hex_hold    <= 8'd0;
            r_field_num   <= 3'd0;
            r_type_pos    <= 3'd0;
            r_num_acc     <= 8'd0;
            r_frag_total  <= 8'd0;
            r_frag_number <= 8'd0;
            r_seq_id      <= 8'd0;
            r_seq_present <= 1'b0;
            r_channel     <= 8'd0;
            r_payload_len <= 7'd0;
            r_line_len    <= 8'd0;
            r_error_code  <= ST_OK;
        end else if (o_take) begin
            r_phase       <= n_phase;
            r_xor_acc     <= n_xor_acc;
            r_hex_hold    <= n_hex_hold;
            r_field_num   <= n_field_num;
            r_type_pos    <= n_type_pos;
            r_num_acc     <= n_num_acc;
            r_frag_total  <= n_frag_total;
            r_frag_number <= n_frag_number;
            r_seq_id      <= n_seq_id;
            r_seq_present <= n_seq_present;
            r_channel     <= n_channel;
            r_payload_len <= n_payload_len;
            r_line_len    <= n_line_len;
            r_error_code  <= n_error_code;
        end
    end

endmodule

FILE: hw/rtl/nmea_aivdm_sentence_parser_unit.sv
// Top level of the AIVDM sentence parser: input skid buffer, parser core, output register.
// Depends on aivdm_pkg, aivdm_in_skid and aivdm_core.
`timescale 1ns / 1ps

// The unit takes one received character per transaction and gives one result per
// payload character, up to 80 per line and only while no error is recorded (a 6-bit
// de-armored symbol), and one verdict per line feed. It sustains one byte per clock
// cycle while the output is not stalled: each byte updates the line state in a single
// pass between the input skid register and the output register, which holds its result.
// Bytes that give no result still pass through the skid register and update the state.
// Output tuser holds the item kind (0 symbol, 1 verdict).
module nmea_aivdm_sentence_parser_unit
    import aivdm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] rx_byte
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [5:0] symbol, [8:6] status, [16:9] frag_total, [24:17] frag_number,
    // [32:25] sequence_id, [33] sequence_present, [41:34] channel_code,
    // [48:42] payload_count, [55:49] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tuser   // [0] item_kind
);

    logic       head_valid;
    logic [7:0] head_data;
    logic       take;
    logic       emit;
    logic       out_free;
    t_result    core_result;

    logic       r_out_valid;
    t_result    r_out;

    // Input side.
    aivdm_in_skid u_in_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata),
        .o_head_valid (head_valid),
        .o_head_data  (head_data),
        .i_pop        (take)
    );

    // Parser.
    aivdm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (head_valid),
        .i_byte       (head_data),
        .i_out_free   (out_free),
        .o_take       (take),
        .o_emit       (emit),
        .o_result     (core_result)
    );

    // Output register frees up in the same cycle its transaction completes.
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= core_result;
        end
    end

    // Output packing.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.item_kind;
    assign o_m_axis_tdata  = {7'd0,
                              r_out.payload_count,
                              r_out.channel_code,
                              r_out.sequence_present,
                              r_out.sequence_id,
                              r_out.frag_number,
                              r_out.frag_total,
                              r_out.status,
                              r_out.symbol};

endmodule
